/* hw/rtl/sbcr_pkg.sv */
package sbcr_pkg;

  localparam int SOURCE_SIZE_DEF = 64;
  // shade levels above LEVEL_COUNT-1 map to the top ramp character
  localparam int LEVEL_COUNT = 10;
  localparam int RAMP_LEN = 10;

  localparam int GRID_W = 9;   // grid dimension register width
  localparam int CELL_W = 8;   // cell coordinate width
  localparam int DIV_W = 11;   // divisor width: grid dimension times four
  localparam int BASE_W = 10;  // scaled cell coordinate: cell*4+3

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] UTF8_LEAD = 8'hE2;
  localparam logic [7:0] UTF8_MID = 8'hA0;
  localparam logic [7:0] UTF8_LAST = 8'h80;

  typedef enum logic [1:0] {
    REG_OUT_WIDTH   = 2'd0,
    REG_OUT_HEIGHT  = 2'd1,
    REG_BRAILLE     = 2'd2,
    REG_INK_THRESH  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DWAIT,
    S_READ,
    S_CMP
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // braille dot bit for sub-dot index {row, column}
  function automatic logic [7:0] dot_mask(input logic [2:0] idx);
    logic [7:0] m;
    unique case (idx)
      3'd0: m = 8'h01;
      3'd1: m = 8'h08;
      3'd2: m = 8'h02;
      3'd3: m = 8'h10;
      3'd4: m = 8'h04;
      3'd5: m = 8'h20;
      3'd6: m = 8'h40;
      3'd7: m = 8'h80;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] shade_char(input logic [3:0] level);
    logic [3:0] lv;
    logic [7:0] c;
    lv = level;
    if (lv >= 4'(LEVEL_COUNT)) lv = 4'(LEVEL_COUNT - 1);
    if (lv >= 4'(RAMP_LEN)) lv = 4'(RAMP_LEN - 1);
    unique case (lv)
      4'd0: c = 8'h20;  // ' '
      4'd1: c = 8'h2E;  // '.'
      4'd2: c = 8'h3A;  // ':'
      4'd3: c = 8'h2D;  // '-'
      4'd4: c = 8'h3D;  // '='
      4'd5: c = 8'h2B;  // '+'
      4'd6: c = 8'h2A;  // '*'
      4'd7: c = 8'h23;  // '#'
      4'd8: c = 8'h25;  // '%'
      default: c = 8'h40;  // '@'
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/sbcr_div.sv */
// Restoring divider, one quotient bit per cycle. The quotient is known to be
// below SOURCE_SIZE, so only QW steps are needed.
module sbcr_div #(
  parameter int SOURCE_SIZE = sbcr_pkg::SOURCE_SIZE_DEF,
  localparam int QW = $clog2(SOURCE_SIZE),
  localparam int NW = sbcr_pkg::BASE_W + $clog2(SOURCE_SIZE + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [NW-1:0]              numerator,
  input  logic [sbcr_pkg::DIV_W-1:0] divisor,
  output sbcr_pkg::div_status_t      status,
  output logic [QW-1:0]              quotient
);
  import sbcr_pkg::*;

  localparam int CW = (NW > DIV_W + QW) ? NW : DIV_W + QW;
  localparam int KW = $clog2(QW + 1);

  logic [CW-1:0] rem;
  logic [CW-1:0] dsh;
  logic [QW-1:0] quo;
  logic [KW-1:0] cnt;
  logic          busy;
  logic          done;
  logic          fits;

  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= KW'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == KW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CW'(numerator);
      dsh <= CW'(divisor) << (QW - 1);
      quo <= '0;
    end else if (busy) begin
      if (fits) rem <= rem - dsh;
      dsh <= dsh >> 1;
      quo <= {quo[QW-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient = quo;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done longer than one cycle");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without work");
`endif

endmodule

/* hw/rtl/scaled_braille_cell_renderer.sv */
// Scaled braille / ASCII cell renderer. A transaction with action=0 writes
// one 4-bit pixel of the SOURCE_SIZE x SOURCE_SIZE source image (busy stays
// low; writes outside the image are dropped). A transaction
// with action=1 renders one output cell: the source is nearest-neighbor
// scaled onto the out_width x out_height grid, cell coordinates saturate to
// the last cell. Braille mode gives a space (byte_count 1) or the three UTF-8
// bytes of the dot glyph; ASCII mode gives one shade-ramp byte. The result
// appears on the result ports for exactly one cycle with result_valid high;
// there is no back-pressure, so the receiver must take it then. Only pixels
// that were written may be sampled. A render is sequenced through one shared
// restoring divider and the single read port of the image memory, and busy
// is high while it runs. The APB port holds the four configuration
// registers at byte addresses 0, 4, 8, 12; write them only while busy is low.
module scaled_braille_cell_renderer #(
  parameter int SOURCE_SIZE = sbcr_pkg::SOURCE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [5:0]  pixel_x,
  input  logic [5:0]  pixel_y,
  input  logic [3:0]  pixel_level,
  input  logic [7:0]  cell_x,
  input  logic [7:0]  cell_y,
  // result
  output logic        result_valid,
  output logic [1:0]  byte_count,
  output logic [7:0]  glyph_byte0,
  output logic [7:0]  glyph_byte1,
  output logic [7:0]  glyph_byte2
);
  import sbcr_pkg::*;

  localparam int QW = $clog2(SOURCE_SIZE);
  localparam int NW = BASE_W + $clog2(SOURCE_SIZE + 1);
  localparam int DEPTH = SOURCE_SIZE * SOURCE_SIZE;
  localparam int AW = $clog2(DEPTH);

  // ---------------- configuration registers ----------------
  logic [GRID_W-1:0] out_width;
  logic [GRID_W-1:0] out_height;
  logic              braille_mode;
  logic [3:0]        ink_threshold;
  logic              cfg_wr;
  cfg_reg_t          cfg_sel;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_width     <= GRID_W'(64);
      out_height    <= GRID_W'(32);
      braille_mode  <= 1'b0;
      ink_threshold <= 4'd2;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_OUT_WIDTH:  out_width     <= pwdata[GRID_W-1:0];
        REG_OUT_HEIGHT: out_height    <= pwdata[GRID_W-1:0];
        REG_BRAILLE:    braille_mode  <= pwdata[0];
        REG_INK_THRESH: ink_threshold <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_OUT_WIDTH:  prdata = 32'(out_width);
      REG_OUT_HEIGHT: prdata = 32'(out_height);
      REG_BRAILLE:    prdata = 32'(braille_mode);
      REG_INK_THRESH: prdata = 32'(ink_threshold);
      default:        prdata = '0;
    endcase
  end

  // ---------------- accept and cell latch ----------------
  logic accept;
  logic acc_render;
  logic acc_write;
  logic [GRID_W-1:0] w_dim;
  logic [GRID_W-1:0] h_dim;
  logic [CELL_W-1:0] cx_sat;
  logic [CELL_W-1:0] cy_sat;

  // grid size 0 acts as 1, above 256 as 256
  always_comb begin
    w_dim = out_width;
    if (out_width == '0) w_dim = GRID_W'(1);
    else if (out_width > GRID_W'(256)) w_dim = GRID_W'(256);
    h_dim = out_height;
    if (out_height == '0) h_dim = GRID_W'(1);
    else if (out_height > GRID_W'(256)) h_dim = GRID_W'(256);
    cx_sat = (GRID_W'(cell_x) > w_dim - 1'b1) ? CELL_W'(w_dim - 1'b1) : cell_x;
    cy_sat = (GRID_W'(cell_y) > h_dim - 1'b1) ? CELL_W'(h_dim - 1'b1) : cell_y;
  end

  assign accept = start && !busy;
  assign acc_render = accept && action;
  assign acc_write = accept && !action;

  state_t state;
  state_t state_next;

  logic [CELL_W-1:0] cx;
  logic [CELL_W-1:0] cy;
  logic [GRID_W-1:0] w_r;
  logic [GRID_W-1:0] h_r;
  logic              mode_r;
  logic [3:0]        thr_r;
  logic [2:0]        job;
  logic [QW-1:0]     sy [4];
  logic [QW-1:0]     sx [2];
  logic [2:0]        rd_idx;
  logic [7:0]        dots;

  // ---------------- division jobs ----------------
  // braille: jobs 0..3 give the four sub-dot rows, 4..5 the two columns
  // ascii:   job 0 gives the row, job 1 the column
  logic                div_start;
  div_status_t         div_st;
  logic [QW-1:0]       div_q;
  logic [BASE_W-1:0]   num_base;
  logic [NW-1:0]       numerator;
  logic [DIV_W-1:0]    divisor;
  logic                job_is_y;
  logic                job_last;

  always_comb begin
    if (mode_r) begin
      job_is_y = !job[2];
      job_last = (job == 3'd5);
      if (job_is_y) begin
        num_base = {cy, job[1:0]};
        divisor  = {h_r, 2'b00};
      end else begin
        num_base = BASE_W'({cx, job[0]});
        divisor  = DIV_W'({w_r, 1'b0});
      end
    end else begin
      job_is_y = (job == 3'd0);
      job_last = (job == 3'd1);
      num_base = job_is_y ? BASE_W'(cy) : BASE_W'(cx);
      divisor  = job_is_y ? DIV_W'(h_r) : DIV_W'(w_r);
    end
    numerator = NW'(num_base) * NW'(SOURCE_SIZE);
  end

  sbcr_div #(.SOURCE_SIZE(SOURCE_SIZE)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .numerator (numerator),
    .divisor   (divisor),
    .status    (div_st),
    .quotient  (div_q)
  );

  // ---------------- image memory ----------------
  logic [3:0]    image_mem [DEPTH];
  logic [3:0]    rd_data;
  logic          mem_rd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_inside;
  logic          rd_last;

  assign wr_inside = (9'(pixel_x) < 9'(SOURCE_SIZE)) && (9'(pixel_y) < 9'(SOURCE_SIZE));
  assign wr_addr = AW'(pixel_y) * AW'(SOURCE_SIZE) + AW'(pixel_x);
  assign rd_addr = AW'(mode_r ? sy[rd_idx[2:1]] : sy[0]) * AW'(SOURCE_SIZE)
                 + AW'(mode_r ? sx[rd_idx[0]] : sx[0]);
  assign rd_last = mode_r ? (rd_idx == 3'd7) : 1'b1;

  always_ff @(posedge clk) begin
    if (acc_write && wr_inside) image_mem[wr_addr] <= pixel_level;
    if (mem_rd) rd_data <= image_mem[rd_addr];
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    mem_rd     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (acc_render) state_next = S_DIV;
      end
      S_DIV: begin
        div_start  = 1'b1;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_st.done) state_next = job_last ? S_READ : S_DIV;
      end
      S_READ: begin
        mem_rd     = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        state_next = rd_last ? S_IDLE : S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  // ---------------- datapath ----------------
  logic       hit;
  logic [7:0] dots_fin;

  assign hit = rd_data >= thr_r;
  assign dots_fin = dots | (hit ? dot_mask(rd_idx) : 8'h00);

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= (state == S_CMP) && rd_last;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && acc_render) begin
      cx     <= cx_sat;
      cy     <= cy_sat;
      w_r    <= w_dim;
      h_r    <= h_dim;
      mode_r <= braille_mode;
      thr_r  <= ink_threshold;
      job    <= '0;
      rd_idx <= '0;
      dots   <= '0;
    end
    if (state == S_DWAIT && div_st.done) begin
      if (job_is_y) sy[job[1:0]] <= div_q;
      else          sx[mode_r ? job[0] : 1'b0] <= div_q;
      job <= job + 1'b1;
    end
    if (state == S_CMP) begin
      dots   <= dots_fin;
      rd_idx <= rd_idx + 1'b1;
      if (rd_last) begin
        if (!mode_r) begin
          byte_count  <= 2'd1;
          glyph_byte0 <= shade_char(rd_data);
          glyph_byte1 <= 8'h00;
          glyph_byte2 <= 8'h00;
        end else if (dots_fin == 8'h00) begin
          byte_count  <= 2'd1;
          glyph_byte0 <= CH_SPACE;
          glyph_byte1 <= 8'h00;
          glyph_byte2 <= 8'h00;
        end else begin
          byte_count  <= 2'd3;
          glyph_byte0 <= UTF8_LEAD;
          glyph_byte1 <= UTF8_MID | {6'b0, dots_fin[7:6]};
          glyph_byte2 <= UTF8_LAST | {2'b0, dots_fin[5:0]};
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_result_from_cmp: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_CMP))
    else $error("result strobe without a finished render");
  a_render_goes_busy: assert property (@(posedge clk) disable iff (rst)
    acc_render |=> busy)
    else $error("render transaction did not start");
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    acc_write |=> !result_valid)
    else $error("pixel write produced a result");
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");
`endif

endmodule
